[src/obrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared sizes, operation codes and the offset reduction table for the
// overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int DATA_W   = 8;
    localparam int OFF_W    = 8;
    localparam int OFF_N    = 1 << OFF_W;

    typedef enum logic [2:0] {
        FN_PUSH  = 3'd0,
        FN_POP   = 3'd1,
        FN_PEEK  = 3'd2,
        FN_ERASE = 3'd3,
        FN_FLUSH = 3'd4
    } t_func;

    localparam logic [DATA_W-1:0] EMPTY_BYTE = 8'hFF;

    typedef logic [ADDR_W-1:0] t_offtab [OFF_N];

    // offset reduced modulo DEPTH, built at elaboration
    function automatic t_offtab mk_offtab();
        t_offtab tab;
        for (int i = 0; i < OFF_N; i++) begin
            tab[i] = ADDR_W'(i % DEPTH);
        end
        return tab;
    endfunction

    localparam t_offtab OFF_MOD = mk_offtab();

endpackage

[src/obrb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/overwriting_byte_ring_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer
// Byte FIFO over a circular RAM; push overwrites the oldest byte when full.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid/o_ready carries i_func (push, pop, peek, erase,
//   flush), i_value, i_offset and i_clear. Every request yields exactly one
//   response on o_valid/i_ready with o_data, o_ok, o_fill, o_is_empty and
//   o_is_full, in request order.
//   Requests pass a read stage, then a response register. Throughput: one
//   request per cycle unless the receiver stalls. Pointers and fill live in
//   registers and update at accept; the byte store is a RAM with one write and
//   one read port, read at accept and consumed at the read stage hand-off, so
//   no access overlaps another. Per-entry valid bits stand in for the zeroed
//   store: flush with clear and reset drop them all, and an entry never written
//   reads as 0. Reset empties the buffer and the two-entry response pipe. When
//   the receiver stalls, the response register holds, one more response waits
//   in the read stage, and o_ready falls until the register drains.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer
    import obrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_func,
    input  logic [DATA_W-1:0] i_value,
    input  logic [OFF_W-1:0]  i_offset,
    input  logic              i_clear,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic              o_ok,
    output logic [FILL_W-1:0] o_fill,
    output logic              o_is_empty,
    output logic              o_is_full
);

    typedef enum logic [1:0] {
        DS_ZERO,
        DS_ONES,
        DS_MEM
    } t_dsel;

    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [DEPTH-1:0]  r_vbits;

    logic              r_s1_valid;
    t_dsel             r_s1_sel, n_sel;
    logic              r_s1_mvld;
    logic              r_s1_ok, n_ok;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_ok;
    logic [FILL_W-1:0] r_out_fill;

    logic              in_acc;
    logic              adv;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] om;
    logic [ADDR_W:0]   psum;
    logic [ADDR_W-1:0] rp_off;
    logic [ADDR_W-1:0] rp_inc;
    logic [ADDR_W-1:0] wp_inc;
    logic [DATA_W-1:0] rdata;
    logic              is_full_now;
    logic              is_empty_now;

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || adv;
    assign in_acc  = i_valid && o_ready;

    assign om     = OFF_MOD[i_offset];
    assign psum   = {1'b0, r_rp} + {1'b0, om};
    assign rp_off = (psum >= (ADDR_W+1)'(DEPTH)) ? ADDR_W'(psum - (ADDR_W+1)'(DEPTH))
                                                 : psum[ADDR_W-1:0];
    assign rp_inc = (r_rp == ADDR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_inc = (r_wp == ADDR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;

    assign is_full_now  = (r_fill == FILL_W'(DEPTH));
    assign is_empty_now = (r_fill == '0);

    always_comb begin
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_fill = r_fill;
        n_sel  = DS_ZERO;
        n_ok   = 1'b1;
        we     = 1'b0;
        re     = 1'b0;
        raddr  = r_rp;
        case (t_func'(i_func))
            FN_PUSH: begin
                we   = in_acc;
                n_wp = wp_inc;
                if (is_full_now) begin
                    n_rp = rp_inc;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            FN_POP: begin
                if (is_empty_now) begin
                    n_sel = DS_ONES;
                end else begin
                    n_sel  = DS_MEM;
                    re     = in_acc;
                    n_rp   = rp_inc;
                    n_fill = r_fill - 1'b1;
                end
            end
            FN_PEEK: begin
                raddr = rp_off;
                if (is_empty_now) begin
                    n_sel = DS_ONES;
                end else begin
                    n_sel = DS_MEM;
                    re    = in_acc;
                end
            end
            FN_ERASE: begin
                if ((OFF_W+FILL_W)'(r_fill) >= (OFF_W+FILL_W)'(i_offset)) begin
                    n_rp   = rp_off;
                    n_fill = r_fill - FILL_W'(i_offset);
                end else begin
                    n_ok = 1'b0;
                end
            end
            FN_FLUSH: begin
                n_wp   = '0;
                n_rp   = '0;
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    obrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (i_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pointer and fill state, updated at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
            r_vbits <= '0;
        end else if (in_acc) begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
            if (t_func'(i_func) == FN_FLUSH && i_clear) begin
                r_vbits <= '0;
            end else if (we) begin
                r_vbits[r_wp] <= 1'b1;
            end
        end
    end

    // read stage and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sel  <= n_sel;
            r_s1_mvld <= r_vbits[raddr];
            r_s1_ok   <= n_ok;
        end
        if (adv && r_s1_valid) begin
            r_out_ok   <= r_s1_ok;
            r_out_fill <= r_fill;
            case (r_s1_sel)
                DS_ONES: r_out_data <= EMPTY_BYTE;
                DS_MEM:  r_out_data <= r_s1_mvld ? rdata : '0;
                default: r_out_data <= '0;
            endcase
        end
    end

    // status comes from the live fill: the read stage holds the newest request,
    // so pointer state at its hand-off is the state after that request

    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;
    assign o_ok       = r_out_ok;
    assign o_fill     = r_out_fill;
    assign o_is_empty = (r_out_fill == '0);
    assign o_is_full  = (r_out_fill == FILL_W'(DEPTH));

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FILL_W'(DEPTH)) |-> r_wp == r_rp)
        else $error("pointers apart while empty or full");

    a_acc_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request lost before read stage");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1_sel) && !$past(in_acc)))
        else $error("stalled read stage changed");

    a_pop_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && re) |-> (r_fill != '0))
        else $error("RAM read issued on empty buffer");

endmodule
